### hdl/slbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slbm_pkg;

  // bus access kinds
  typedef enum logic [1:0] {
    ACT_CPU_READ  = 2'd0,
    ACT_CPU_WRITE = 2'd1,
    ACT_PPU       = 2'd2,
    ACT_RESET     = 2'd3
  } action_t;

  // stores an access can reach
  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_RAM  = 2'd1,
    TGT_PRG  = 2'd2,
    TGT_CHR  = 2'd3
  } target_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PRG_BANK_COUNT = 2'd0,
    CFG_START_VERTICAL = 2'd1,
    CFG_QUIET_READS    = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_index_t;

  // program ROM layouts, mode_control bits 3..2
  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

  // target register select, address bits 14..13
  localparam logic [1:0] SEL_CONTROL  = 2'd0;
  localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
  localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
  localparam logic [1:0] SEL_PRG      = 2'd3;

  localparam logic [15:0] RAM_BASE = 16'h6000;
  localparam logic [15:0] ROM_BASE = 16'h8000;

  localparam logic [4:0] SHIFT_EMPTY      = 5'd16;
  localparam logic [4:0] CONTROL_RESET    = 5'd15;
  localparam logic [4:0] CONTROL_VERTICAL = 5'd14;
  localparam logic [4:0] CONTROL_PRG_LOCK = 5'h0C;

  localparam int CFG_DATA_W = 5;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  value;
  } in_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [17:0] offset;
    logic [1:0]  mirror_mode;
    logic        bank_error;
  } out_t;

endpackage

`default_nettype wire

### hdl/serial_loaded_bank_mapper_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// An accepted access waits in the input register until the result register is empty or drained.
// Throughput: one access per cycle while results drain; decode and bank select are combinational.
// The input register takes a beat while a finished result still waits on the output side.
// Reset (rst, synchronous, active high) empties both stages, restores the mapper registers
// (control 15, serial shift marker only, banks 0) and the configuration defaults.
module serial_loaded_bank_mapper_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire slbm_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output slbm_pkg::out_t       out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [slbm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import slbm_pkg::*;

  // configuration
  logic [4:0] prg_bank_count;
  logic       start_vertical;
  logic       quiet_reads;

  // mapper state
  logic [4:0] load_shift, load_shift_next;
  logic [4:0] mode_control, mode_control_next;
  logic [4:0] chr_bank_low, chr_bank_low_next;
  logic [4:0] chr_bank_high, chr_bank_high_next;
  logic [3:0] prg_bank, prg_bank_next;
  logic       write_suppress, write_suppress_next;

  // input stage
  logic inq_valid;
  in_t  inq;
  logic advance;

  out_t result;

  // A held beat moves on when the result register is empty or being drained.
  assign advance   = inq_valid && (!out_valid || out_ready);
  assign in_ready  = !inq_valid || advance;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Decode and state update for the beat in the input register
  // ---------------------------------------------------------------------------
  logic        upper_prg;
  logic        upper_chr;
  logic [1:0]  prg_mode;
  logic [4:0]  last_bank;
  logic [4:0]  prg_sel;
  logic [4:0]  chr_sel;
  logic [17:0] prg_offset;
  logic [17:0] chr_offset;
  logic [15:0] ram_offset;
  logic [4:0]  shifted;

  always_comb begin
    upper_prg = inq.address[14];
    upper_chr = inq.address[12];
    prg_mode  = mode_control[3:2];
    last_bank = prg_bank_count - 5'd1;

    case (prg_mode)
      PRG_MODE_FIX_FIRST: prg_sel = upper_prg ? {1'b0, prg_bank} : 5'd0;
      PRG_MODE_FIX_LAST:  prg_sel = upper_prg ? last_bank : {1'b0, prg_bank};
      default:            prg_sel = {1'b0, prg_bank[3:1], upper_prg};
    endcase
    // 18-bit offset keeps four bank bits
    prg_offset = {prg_sel[3:0], inq.address[13:0]};

    if (!mode_control[4]) begin
      chr_sel = {chr_bank_low[4:1], upper_chr};
    end else begin
      chr_sel = upper_chr ? chr_bank_high : chr_bank_low;
    end
    chr_offset = {1'b0, chr_sel, inq.address[11:0]};

    ram_offset = inq.address - RAM_BASE;
    shifted    = {inq.value[0], load_shift[4:1]};
  end

  always_comb begin
    load_shift_next     = load_shift;
    mode_control_next   = mode_control;
    chr_bank_low_next   = chr_bank_low;
    chr_bank_high_next  = chr_bank_high;
    prg_bank_next       = prg_bank;
    write_suppress_next = write_suppress;
    result.target       = TGT_NONE;
    result.offset       = '0;

    case (action_t'(inq.action))
      ACT_CPU_READ: begin
        if (!quiet_reads) begin
          write_suppress_next = 1'b0;
        end
        if (inq.address >= ROM_BASE) begin
          result.target = TGT_PRG;
          result.offset = prg_offset;
        end else if (inq.address >= RAM_BASE) begin
          result.target = TGT_RAM;
          result.offset = {2'b00, ram_offset};
        end
      end
      ACT_CPU_WRITE: begin
        if (inq.address >= ROM_BASE) begin
          // serial load port; a write right after another write is dropped
          if (!write_suppress) begin
            write_suppress_next = 1'b1;
            if (inq.value[7]) begin
              load_shift_next   = SHIFT_EMPTY;
              mode_control_next = mode_control | CONTROL_PRG_LOCK;
            end else if (load_shift[0]) begin
              // fifth bit: commit to the register picked by address bits 14..13
              load_shift_next = SHIFT_EMPTY;
              case (inq.address[14:13])
                SEL_CONTROL:  mode_control_next  = shifted;
                SEL_CHR_LOW:  chr_bank_low_next  = shifted;
                SEL_CHR_HIGH: chr_bank_high_next = shifted;
                SEL_PRG:      prg_bank_next      = shifted[3:0];
                default:      prg_bank_next      = prg_bank;
              endcase
            end else begin
              load_shift_next = shifted;
            end
          end
        end else if (inq.address >= RAM_BASE) begin
          result.target = TGT_RAM;
          result.offset = {2'b00, ram_offset};
        end
      end
      ACT_PPU: begin
        result.target = TGT_CHR;
        result.offset = chr_offset;
      end
      ACT_RESET: begin
        load_shift_next     = SHIFT_EMPTY;
        write_suppress_next = 1'b0;
        mode_control_next   = start_vertical ? CONTROL_VERTICAL : CONTROL_RESET;
        prg_bank_next       = '0;
        chr_bank_low_next   = '0;
        chr_bank_high_next  = '0;
      end
      default: begin
        result.target = TGT_NONE;
      end
    endcase

    // mirroring and bank check reflect the state this access leaves behind
    result.mirror_mode = mode_control_next[1:0];
    result.bank_error  = ({1'b0, prg_bank_next} >= prg_bank_count);
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= 5'd1;
      start_vertical <= 1'b0;
      quiet_reads    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_PRG_BANK_COUNT: prg_bank_count <= cfg_data;
        CFG_START_VERTICAL: start_vertical <= cfg_data[0];
        CFG_QUIET_READS:    quiet_reads    <= cfg_data[0];
        default:            quiet_reads    <= quiet_reads;  // drop writes past the list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_shift     <= SHIFT_EMPTY;
      mode_control   <= CONTROL_RESET;
      chr_bank_low   <= '0;
      chr_bank_high  <= '0;
      prg_bank       <= '0;
      write_suppress <= 1'b0;
    end else if (advance) begin
      load_shift     <= load_shift_next;
      mode_control   <= mode_control_next;
      chr_bank_low   <= chr_bank_low_next;
      chr_bank_high  <= chr_bank_high_next;
      prg_bank       <= prg_bank_next;
      write_suppress <= write_suppress_next;
    end
  end

  // input register: hold the beat until it advances
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

`ifndef ASSERT_OFF
  // the shift register always carries its marker bit
  a_shift_marker: assert property (@(posedge clk) disable iff (rst)
    load_shift != 5'd0)
    else $error("load_shift lost its marker bit");

  // an advancing beat always lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced beat did not produce a result");

  // an accepted serial write to ROM space arms write suppression
  a_suppress_arm: assert property (@(posedge clk) disable iff (rst)
    advance && inq.action == ACT_CPU_WRITE && inq.address >= ROM_BASE |=> write_suppress)
    else $error("ROM write did not set write_suppress");

  // no target means a zero offset
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.target == TGT_NONE |-> out_data.offset == 18'd0)
    else $error("nonzero offset with no target");

  // an empty input register always takes a beat
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !inq_valid |-> in_ready)
    else $error("empty input stage refused a beat");
`endif

endmodule

`default_nettype wire

### sim/bank_mapper_checker.sv
`timescale 1ns / 1ps

// Watches the access, result and register channels, keeps a shadow of the
// mapper registers and checks every result beat against the oldest prediction.
module bank_mapper_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  slbm_pkg::in_t                in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  slbm_pkg::out_t               out_data,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [slbm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                           fail_count,
  output int                           pending_count
);
  import slbm_pkg::*;

  // shadow configuration
  logic [4:0] bank_count_q;
  logic       vertical_q;
  logic       quiet_q;

  // shadow mapper state
  logic [4:0] shift_q;
  logic [4:0] control_q;
  logic [4:0] chr_lo_q;
  logic [4:0] chr_hi_q;
  logic [3:0] prg_q;
  logic       suppress_q;

  out_t expected_maps[$];
  out_t predicted;
  out_t oldest;
  int   mismatches = 0;

  function automatic void restart_mapper();
    shift_q    = SHIFT_EMPTY;
    suppress_q = 1'b0;
    control_q  = vertical_q ? CONTROL_VERTICAL : CONTROL_RESET;
    prg_q      = '0;
    chr_lo_q   = '0;
    chr_hi_q   = '0;
  endfunction

  function automatic void note_mismatch(string field, logic [17:0] want, logic [17:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %s mismatch, expected 'h%0h, got 'h%0h", $time, field, want, got);
  endfunction

  // Decode one bus access and advance the shadow state.
  task automatic map_access(input in_t beat, output out_t res);
    logic [15:0] addr;
    target_t     tgt;
    logic [17:0] off;
    logic [4:0]  bank;
    logic        fifth;
    addr = beat.address;
    tgt  = TGT_NONE;
    off  = '0;
    case (action_t'(beat.action))
      ACT_CPU_READ: begin
        if (!quiet_q)
          suppress_q = 1'b0;
        if (addr >= ROM_BASE) begin
          case (control_q[3:2])
            PRG_MODE_FIX_FIRST: bank = addr[14] ? {1'b0, prg_q} : 5'd0;
            PRG_MODE_FIX_LAST:  bank = addr[14] ? bank_count_q - 5'd1 : {1'b0, prg_q};
            default:            bank = {1'b0, prg_q[3:1], addr[14]};
          endcase
          tgt = TGT_PRG;
          // 16 KiB banks; only the low 18 bits of the offset survive
          off = {bank[3:0], addr[13:0]};
        end else if (addr >= RAM_BASE) begin
          tgt = TGT_RAM;
          off = 18'(addr - RAM_BASE);
        end
      end
      ACT_CPU_WRITE: begin
        if (addr >= ROM_BASE) begin
          if (!suppress_q) begin
            suppress_q = 1'b1;
            if (beat.value[7]) begin
              shift_q   = SHIFT_EMPTY;
              control_q = control_q | CONTROL_PRG_LOCK;
            end else begin
              // marker bit reaching bit 0 means this is the fifth bit
              fifth   = shift_q[0];
              shift_q = {beat.value[0], shift_q[4:1]};
              if (fifth) begin
                case (addr[14:13])
                  SEL_CONTROL:  control_q = shift_q;
                  SEL_CHR_LOW:  chr_lo_q  = shift_q;
                  SEL_CHR_HIGH: chr_hi_q  = shift_q;
                  default:      prg_q     = shift_q[3:0];
                endcase
                shift_q = SHIFT_EMPTY;
              end
            end
          end
        end else if (addr >= RAM_BASE) begin
          tgt = TGT_RAM;
          off = 18'(addr - RAM_BASE);
        end
      end
      ACT_PPU: begin
        if (!control_q[4])
          bank = {chr_lo_q[4:1], addr[12]};
        else
          bank = addr[12] ? chr_hi_q : chr_lo_q;
        tgt = TGT_CHR;
        off = {1'b0, bank, addr[11:0]};
      end
      default: restart_mapper();
    endcase
    res.target      = tgt;
    res.offset      = off;
    res.mirror_mode = control_q[1:0];
    res.bank_error  = ({1'b0, prg_q} >= bank_count_q);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bank_count_q = 5'd1;
      vertical_q   = 1'b0;
      quiet_q      = 1'b0;
      restart_mapper();
      expected_maps.delete();
    end else begin
      // retire before predicting: a result never leaves on its own accept edge
      if (out_valid && out_ready) begin
        if (expected_maps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t ns: result beat with nothing expected, got 'h%0h", $time, out_data);
        end else begin
          oldest = expected_maps.pop_front();
          if (out_data.target !== oldest.target)
            note_mismatch("target", oldest.target, out_data.target);
          if (out_data.offset !== oldest.offset)
            note_mismatch("offset", oldest.offset, out_data.offset);
          if (out_data.mirror_mode !== oldest.mirror_mode)
            note_mismatch("mirror_mode", oldest.mirror_mode, out_data.mirror_mode);
          if (out_data.bank_error !== oldest.bank_error)
            note_mismatch("bank_error", oldest.bank_error, out_data.bank_error);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PRG_BANK_COUNT: bank_count_q = cfg_data;
          CFG_START_VERTICAL: vertical_q   = cfg_data[0];
          CFG_QUIET_READS:    quiet_q      = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        map_access(in_data, predicted);
        expected_maps.push_back(predicted);
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_maps.size();
  end

endmodule

### sim/serial_loaded_bank_mapper_unit_test.sv
`timescale 1ns / 1ps

module serial_loaded_bank_mapper_unit_test;
  import slbm_pkg::*;

  // generous bound: every access paying the longest sender gap and receiver stall
  localparam int CYCLE_LIMIT   = 400_000;
  // two-stage pipe plus margin
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS   = 205;

  logic clk = 1'b0;
  logic rst;

  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending_count;
  int sent_items;
  int cycle_count;
  bit steady;   // no sender gaps while set

  always #2 clk = ~clk;

  serial_loaded_bank_mapper_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predict and compare beside the block; only the verdict comes back here.
  bank_mapper_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Mostly zero or short, now and then a long pause.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Send one bus access. Valid stays high after the beat so back-to-back
  // accesses never lower and raise it in the same step; a gap drops it.
  task automatic send_access(action_t act, logic [15:0] addr, logic [7:0] val);
    int   gap;
    in_t  beat;
    gap = steady ? 0 : idle_len();
    beat.action  = act;
    beat.address = addr;
    beat.value   = val;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    // hold the beat until the block takes it
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  // Drop valid and wait out every outstanding result, then the pipe depth.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Five serial writes, each followed by a read that clears write suppression
  // while quiet reads are off. With may_break set, sometimes abort with a bit-7
  // write or skip the read so the next write lands on a suppressed bus.
  task automatic load_register(logic [1:0] sel, logic [4:0] data, bit may_break);
    int i;
    for (i = 0; i < 5; i++) begin
      if (may_break && $urandom_range(0, 24) == 0) begin
        send_access(ACT_CPU_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
        return;
      end
      send_access(ACT_CPU_WRITE, {1'b1, sel, 13'($urandom)}, {1'b0, 6'($urandom), data[i]});
      if (!may_break || $urandom_range(0, 19) != 0)
        send_access(ACT_CPU_READ, 16'($urandom), 8'($urandom));
      // peek at the pattern side while the load is half done
      if (may_break && $urandom_range(0, 3) == 0)
        send_access(ACT_PPU, 16'($urandom), 8'($urandom));
    end
  endtask

  // One configuration setting followed by a random mix of register loads,
  // reset actions and stray accesses.
  task automatic run_phase(logic [4:0] count, bit vertical, bit quiet, bit touch_spare);
    int stop;
    int pick;
    settle();
    write_reg(CFG_PRG_BANK_COUNT, count);
    // only bit 0 matters; fill the rest with noise
    write_reg(CFG_START_VERTICAL, {4'($urandom), vertical});
    write_reg(CFG_QUIET_READS, {4'($urandom), quiet});
    if (touch_spare)
      write_reg(CFG_UNUSED, 5'($urandom));
    cfg_valid <= 1'b0;
    steady = ($urandom_range(0, 2) == 0);
    stop = sent_items + PHASE_ITEMS;
    while (sent_items < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)
        load_register(2'($urandom), 5'($urandom), 1'b1);
      else if (pick < 66)
        send_access(ACT_RESET, 16'($urandom), 8'($urandom));
      else
        repeat ($urandom_range(1, 4))
          send_access(action_t'($urandom_range(0, 2)), 16'($urandom), 8'($urandom));
    end
  endtask

  // Result side: runs of ready broken by stalls, some runs long enough to
  // leave the pipe free-flowing for a while.
  initial begin : result_side
    int run;
    int hold;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      hold = idle_len();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** serial_loaded_bank_mapper_unit: FAILED **");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_PRG_BANK_COUNT;
    cfg_data   = '0;
    steady     = 1'b0;
    sent_items = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, default settings: one bank, horizontal, reads clear suppression.
    send_access(ACT_CPU_READ,  16'h0000, 8'h00);  // below cartridge RAM: nothing
    send_access(ACT_CPU_READ,  16'h5FFF, 8'hFF);  // last address below RAM
    send_access(ACT_CPU_READ,  16'h6000, 8'h00);  // first RAM byte
    send_access(ACT_CPU_WRITE, 16'h7FFF, 8'hFF);  // RAM write, last byte
    send_access(ACT_CPU_WRITE, 16'h5FFF, 8'hFF);  // write below RAM is dropped
    send_access(ACT_CPU_READ,  16'h8000, 8'h00);  // switchable bank at reset layout
    send_access(ACT_CPU_READ,  16'hFFFF, 8'h00);  // fixed last bank
    send_access(ACT_PPU,       16'h0000, 8'h00);
    send_access(ACT_PPU,       16'hFFFF, 8'hFF);  // upper address bits ignored
    send_access(ACT_CPU_WRITE, 16'h8000, 8'h80);  // bit 7: clear shift, lock layout
    send_access(ACT_CPU_WRITE, 16'h8000, 8'h01);  // back-to-back write is suppressed
    send_access(ACT_CPU_READ,  16'hC000, 8'h00);  // read clears suppression
    // program bank 15 with one bank present: bank flag raised
    load_register(SEL_PRG, 5'h1F, 1'b0);
    send_access(ACT_CPU_READ,  16'hBFFF, 8'h00);  // top of the widest offset
    send_access(ACT_CPU_READ,  16'hC000, 8'h00);
    send_access(ACT_RESET,     16'hFFFF, 8'hFF);
    send_access(ACT_PPU,       16'h1000, 8'h00);

    // Settings sweep: bank count at zero, one, sixteen and its field maximum.
    run_phase(5'd16, 1'b1, 1'b0, 1'b0);
    run_phase(5'd1,  1'b0, 1'b1, 1'b0);
    run_phase(5'd0,  1'b1, 1'b0, 1'b1);
    run_phase(5'd31, 1'b0, 1'b0, 1'b0);
    run_phase(5'($urandom_range(2, 15)), 1'($urandom), 1'b0, 1'b0);
    run_phase(5'($urandom), 1'($urandom), 1'($urandom), 1'b0);

    settle();
    if (fail_count == 0)
      $display("** serial_loaded_bank_mapper_unit: PASSED **");
    else
      $display("** serial_loaded_bank_mapper_unit: FAILED **");
    $finish;
  end

endmodule
